[hdl/lru_page_replacement_top_defines.svh]
// Assertion macros shared by the replacement-policy RTL
`ifndef LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define LRU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define LRU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lru_pr_pkg.sv]
package lru_pr_pkg;

	// Default geometry
	localparam int NUM_FRAMES_DEF = 8;
	localparam int PAGE_BITS_DEF  = 27;

	// Width of the resident count result field
	localparam int RES_CNT_W = 4;

	// Event codes
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_TOUCH  = 2'd1,
		MODE_EVICT  = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

endpackage

[hdl/lru_page_replacement_top.sv]
// Channel   Handshake          Transfer when              Payload
// event     start / busy       start high and busy low    mode, page_number
// result    done (strobe)      the cycle done is high     victim_page, victim_valid,
//                                                         hit, full_error, resident_count
//
// Each event sweeps the frame memory once; an insert or touch that changes ranks sweeps
// it a second time to write them back.
// The sweep length is set by the single read and single write port of the frame memory.
// done pulses for one cycle as busy drops; the next event can start in that cycle.
// arst_n clears the valid bits, occupancy and control; the frame memory is not cleared.
// The receiver cannot stall: the result is shown exactly once, in the done cycle.

`include "lru_page_replacement_top_defines.svh"

module lru_page_replacement_top
	import lru_pr_pkg::*;
#(
	parameter int NUM_FRAMES       = NUM_FRAMES_DEF,
	parameter int PAGE_NUMBER_BITS = PAGE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  mode,
	input  logic [PAGE_NUMBER_BITS-1:0] page_number,
	output logic                        done,
	output logic [PAGE_NUMBER_BITS-1:0] victim_page,
	output logic                        victim_valid,
	output logic                        hit,
	output logic                        full_error,
	output logic [RES_CNT_W-1:0]        resident_count
);

	localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int RW = IW;
	localparam int OW = $clog2(NUM_FRAMES + 1);
	localparam int WW = PAGE_NUMBER_BITS + RW;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_FRAMES - 1);
	localparam logic [OW-1:0] FULL_OCC = OW'(NUM_FRAMES);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t                      state_q;
	logic [IW-1:0]               cnt_q;
	logic                        iss_q;
	logic                        rd_vld_s1;
	logic [IW-1:0]               rd_idx_s1;
	logic [WW-1:0]               rd_word_s1;
	logic [NUM_FRAMES-1:0]       valid_q;
	logic [OW-1:0]               occ_q;
	mode_t                       mode_q;
	logic [PAGE_NUMBER_BITS-1:0] pg_q;
	logic                        found_q;
	logic [IW-1:0]               fidx_q;
	logic [RW-1:0]               frank_q;
	logic                        free_found_q;
	logic [IW-1:0]               free_idx_q;
	logic [PAGE_NUMBER_BITS-1:0] vpage_q;
	logic                        done_q;
	logic [PAGE_NUMBER_BITS-1:0] res_victim_q;
	logic                        res_vvalid_q;
	logic                        res_hit_q;
	logic                        res_ferr_q;

	// Frame memory: {page, rank} per frame
	logic [WW-1:0] mem [NUM_FRAMES];

	logic                        accept;
	logic                        sweep_end;
	logic                        ent_v;
	logic [PAGE_NUMBER_BITS-1:0] rd_page;
	logic [RW-1:0]               rd_rank;
	logic                        wr_en;
	logic [WW-1:0]               wr_word;
	logic [RW-1:0]               new_rank;

	assign accept    = start && (state_q == ST_IDLE);
	assign sweep_end = !iss_q && !rd_vld_s1;
	assign ent_v     = valid_q[rd_idx_s1];
	assign rd_page   = rd_word_s1[WW-1:RW];
	assign rd_rank   = rd_word_s1[RW-1:0];

	// Rank rewrite during the update sweep
	always_comb begin
		new_rank = rd_rank;
		wr_word  = {rd_page, rd_rank};
		if (found_q) begin
			if (rd_idx_s1 == fidx_q) begin
				new_rank = '0;
			end else if (rd_rank < frank_q) begin
				new_rank = rd_rank + 1'b1;
			end
			wr_word = {rd_page, new_rank};
		end else if (ent_v) begin
			new_rank = rd_rank + 1'b1;
			wr_word  = {rd_page, new_rank};
		end else begin
			wr_word = {pg_q, {RW{1'b0}}};
		end
	end

	assign wr_en = (state_q == ST_UPDATE) && rd_vld_s1 &&
		(ent_v || (!found_q && (rd_idx_s1 == free_idx_q)));

	// Memory: one read, one write per cycle; a sweep never reads the entry it writes
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[rd_idx_s1] <= wr_word;
		end
		if (iss_q) begin
			rd_word_s1 <= mem[cnt_q];
		end
	end

	// Sweep control, search and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			iss_q        <= 1'b0;
			rd_vld_s1    <= 1'b0;
			valid_q      <= '0;
			occ_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q       <= mode_t'(mode);
						pg_q         <= page_number;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						cnt_q        <= '0;
						iss_q        <= 1'b1;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN, ST_UPDATE: begin
					// Address issue and read pipeline
					rd_vld_s1 <= iss_q;
					rd_idx_s1 <= cnt_q;
					if (iss_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == LAST_IDX) begin
							iss_q <= 1'b0;
						end
					end

					// Search on returned entries
					if (state_q == ST_SCAN && rd_vld_s1) begin
						if (mode_q == MODE_EVICT) begin
							if (ent_v && (!found_q || rd_rank > frank_q)) begin
								found_q <= 1'b1;
								fidx_q  <= rd_idx_s1;
								frank_q <= rd_rank;
								vpage_q <= rd_page;
							end
						end else begin
							if (ent_v && rd_page == pg_q && !found_q) begin
								found_q <= 1'b1;
								fidx_q  <= rd_idx_s1;
								frank_q <= rd_rank;
							end
							if (!ent_v && !free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= rd_idx_s1;
							end
						end
					end

					// End of the search sweep: decide the event
					if (state_q == ST_SCAN && sweep_end) begin
						res_victim_q <= '0;
						res_vvalid_q <= 1'b0;
						res_hit_q    <= 1'b0;
						res_ferr_q   <= 1'b0;
						state_q      <= ST_IDLE;
						done_q       <= 1'b1;
						case (mode_q) inside
							MODE_INSERT, MODE_TOUCH: begin
								if (found_q) begin
									res_hit_q <= 1'b1;
									state_q   <= ST_UPDATE;
									done_q    <= 1'b0;
									cnt_q     <= '0;
									iss_q     <= 1'b1;
								end else if (mode_q == MODE_INSERT) begin
									if (occ_q >= FULL_OCC) begin
										res_ferr_q <= 1'b1;
									end else begin
										state_q <= ST_UPDATE;
										done_q  <= 1'b0;
										cnt_q   <= '0;
										iss_q   <= 1'b1;
									end
								end
							end
							MODE_EVICT: begin
								if (found_q) begin
									res_victim_q    <= vpage_q;
									res_vvalid_q    <= 1'b1;
									valid_q[fidx_q] <= 1'b0;
									occ_q           <= occ_q - 1'b1;
								end
							end
							default: begin
							end
						endcase
					end

					// End of the rank write-back sweep
					if (state_q == ST_UPDATE && sweep_end) begin
						if (!found_q) begin
							valid_q[free_idx_q] <= 1'b1;
							occ_q               <= occ_q + 1'b1;
						end
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign victim_page    = res_victim_q;
	assign victim_valid   = res_vvalid_q;
	assign hit            = res_hit_q;
	assign full_error     = res_ferr_q;
	assign resident_count = RES_CNT_W'(occ_q);

	`LRU_ASSERT_IMP(a_occ_matches_valid, 1'b1, $countones(valid_q) == occ_q,
		"occupancy disagrees with the valid bits")
	`LRU_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= FULL_OCC,
		"occupancy above frame count")
	`LRU_ASSERT_NXT(a_start_busy, accept, busy,
		"accepted event did not raise busy")
	`LRU_ASSERT_IMP(a_full_only_when_full, done && full_error, occ_q == FULL_OCC,
		"refused insert while frames were free")
	`LRU_ASSERT_IMP(a_hit_keeps_valid, done && hit, $stable(valid_q),
		"hit changed the set of resident frames")

endmodule

[sim/lru_page_replacement_top_tb.sv]
module lru_page_replacement_top_tb;
	import lru_pr_pkg::*;

	localparam int NF = NUM_FRAMES_DEF;
	localparam int PB = PAGE_BITS_DEF;
	localparam logic [PB-1:0] PAGE_MAX = {PB{1'b1}};
	// worst event: two sweeps over the frames plus overhead
	localparam int EVENT_CYCLES = 2 * NF + 4;
	localparam int DRAIN_CYCLES = 3 * EVENT_CYCLES;
	localparam int IDLE_LIMIT = 400;
	localparam int RANDOM_EVENTS = 1200;
	localparam int SEGMENT_LEN = 100;
	localparam int POOL_SIZE = 12;

	typedef struct {
		logic [PB-1:0]        victim;
		logic                 vvalid;
		logic                 hit;
		logic                 ferr;
		logic [RES_CNT_W-1:0] count;
	} outcome_t;

	typedef struct {
		mode_t         m;
		logic [PB-1:0] pg;
		bit            fixed;
		outcome_t      res;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [1:0]           mode = MODE_INSERT;
	logic [PB-1:0]        page_number = '0;
	logic                 done;
	logic [PB-1:0]        victim_page;
	logic                 victim_valid;
	logic                 hit;
	logic                 full_error;
	logic [RES_CNT_W-1:0] resident_count;

	// Shadow of the frame table
	logic [PB-1:0] frm_page [NF];
	bit            frm_vld [NF];
	int            frm_rank [NF];
	int            occ = 0;

	outcome_t outcome_q [$];
	dir_row_t dir_rows [$];
	outcome_t want;
	outcome_t predicted;

	// Typed expectation handed from the driver to the monitor
	bit       fix_pending = 1'b0;
	outcome_t fix_value;

	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int n_ins = 0, n_tch = 0, n_evt = 0, n_rsvd = 0;
	int n_hit = 0, n_full = 0, n_victim = 0, n_empty = 0, max_occ = 0;

	lru_page_replacement_top #(
		.NUM_FRAMES      (NF),
		.PAGE_NUMBER_BITS(PB)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.page_number   (page_number),
		.done          (done),
		.victim_page   (victim_page),
		.victim_valid  (victim_valid),
		.hit           (hit),
		.full_error    (full_error),
		.resident_count(resident_count)
	);

	always #5 clk = ~clk;

	// Applies one event to the shadow table and returns the outcome it should give
	function automatic outcome_t lru_event_outcome(mode_t m, logic [PB-1:0] pg);
		outcome_t o;
		int f;
		int r;
		bit placed;
		o.victim = '0;
		o.vvalid = 1'b0;
		o.hit = 1'b0;
		o.ferr = 1'b0;
		f = -1;
		placed = 1'b0;
		case (m)
			MODE_INSERT, MODE_TOUCH: begin
				for (int i = 0; i < NF; i++)
					if (f < 0 && frm_vld[i] && frm_page[i] == pg)
						f = i;
				if (f >= 0) begin
					// present page moves to the front; newer ones age by one
					o.hit = 1'b1;
					r = frm_rank[f];
					for (int i = 0; i < NF; i++)
						if (frm_vld[i] && i != f && frm_rank[i] < r)
							frm_rank[i]++;
					frm_rank[f] = 0;
				end else if (m == MODE_INSERT) begin
					if (occ >= NF) begin
						o.ferr = 1'b1;
					end else begin
						for (int i = 0; i < NF; i++)
							if (frm_vld[i])
								frm_rank[i]++;
						for (int i = 0; i < NF; i++)
							if (!placed && !frm_vld[i]) begin
								frm_vld[i] = 1'b1;
								frm_page[i] = pg;
								frm_rank[i] = 0;
								placed = 1'b1;
							end
						occ++;
					end
				end
			end
			MODE_EVICT: begin
				// least recent = highest rank
				for (int i = 0; i < NF; i++)
					if (frm_vld[i] && (f < 0 || frm_rank[i] > frm_rank[f]))
						f = i;
				if (f >= 0) begin
					o.victim = frm_page[f];
					o.vvalid = 1'b1;
					frm_vld[f] = 1'b0;
					occ--;
				end
			end
			default: ;
		endcase
		o.count = occ[RES_CNT_W-1:0];
		return o;
	endfunction

	task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
		end
	endtask

	// Result check and event capture, both on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					errors++;
					$display("%0t: result transfer with no outcome pending", $time);
				end else begin
					want = outcome_q.pop_front();
					cmp_field("victim_page", 32'(want.victim), 32'(victim_page));
					cmp_field("victim_valid", 32'(want.vvalid), 32'(victim_valid));
					cmp_field("hit", 32'(want.hit), 32'(hit));
					cmp_field("full_error", 32'(want.ferr), 32'(full_error));
					cmp_field("resident_count", 32'(want.count), 32'(resident_count));
				end
			end
			if (start && !busy) begin
				predicted = lru_event_outcome(mode_t'(mode), page_number);
				case (mode_t'(mode))
					MODE_INSERT: n_ins++;
					MODE_TOUCH:  n_tch++;
					MODE_EVICT:  n_evt++;
					default:     n_rsvd++;
				endcase
				if (predicted.hit) n_hit++;
				if (predicted.ferr) n_full++;
				if (predicted.vvalid) n_victim++;
				if (mode_t'(mode) == MODE_EVICT && !predicted.vvalid) n_empty++;
				if (occ > max_occ) max_occ = occ;
				if (fix_pending)
					outcome_q.push_back(fix_value);
				else
					outcome_q.push_back(predicted);
			end
		end
	end

	// Watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if (done || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic add_row(mode_t m, logic [PB-1:0] pg);
		dir_row_t row;
		row.m = m;
		row.pg = pg;
		row.fixed = 1'b0;
		row.res = '{default: '0};
		dir_rows.push_back(row);
	endtask

	// Row with a typed outcome; victim fields are zero in all of them
	task automatic add_fixed(mode_t m, logic [PB-1:0] pg, bit h, bit fe, int cnt);
		dir_row_t row;
		row.m = m;
		row.pg = pg;
		row.fixed = 1'b1;
		row.res.victim = '0;
		row.res.vvalid = 1'b0;
		row.res.hit = h;
		row.res.ferr = fe;
		row.res.count = cnt[RES_CNT_W-1:0];
		dir_rows.push_back(row);
	endtask

	// Drive one event at the falling edge and hold it until the transfer
	task automatic drive_event(mode_t m, logic [PB-1:0] pg, bit fixed, outcome_t fx);
		fix_pending = fixed;
		fix_value = fx;
		start <= 1'b1;
		mode <= m;
		page_number <= pg;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Sender bursts: after a burst, drop start for a random gap
	task automatic pace();
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 10);
		end else begin
			burst_left--;
		end
	endtask

	initial begin
		logic [PB-1:0] pool [POOL_SIZE];
		logic [PB-1:0] pg;
		outcome_t none;
		mode_t m;
		int evict_pct;
		int r;

		none = '{default: '0};
		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = PB'($urandom);

		// empty set, unused mode, touch miss
		add_fixed(MODE_EVICT, PAGE_MAX, 0, 0, 0);
		add_fixed(MODE_RSVD, 'h123, 0, 0, 0);
		add_fixed(MODE_TOUCH, '0, 0, 0, 0);
		// fill with extreme page numbers, re-insert and touch hits
		add_fixed(MODE_INSERT, '0, 0, 0, 1);
		add_fixed(MODE_INSERT, PAGE_MAX, 0, 0, 2);
		add_fixed(MODE_INSERT, '0, 1, 0, 2);
		add_fixed(MODE_TOUCH, PAGE_MAX, 1, 0, 2);
		add_fixed(MODE_TOUCH, 'h5555555, 0, 0, 2);
		add_fixed(MODE_INSERT, 'h5555555, 0, 0, 3);
		add_fixed(MODE_INSERT, 'h2AAAAAA, 0, 0, 4);
		add_fixed(MODE_INSERT, 'h0000001, 0, 0, 5);
		add_fixed(MODE_INSERT, 'h4000000, 0, 0, 6);
		add_fixed(MODE_INSERT, 'h0001000, 0, 0, 7);
		add_fixed(MODE_INSERT, 'h1234567, 0, 0, 8);
		// full set: new page refused, present page still hits
		add_fixed(MODE_INSERT, 'h7654321, 0, 1, 8);
		add_fixed(MODE_INSERT, '0, 1, 0, 8);
		add_fixed(MODE_RSVD, PAGE_MAX, 0, 0, 8);
		add_row(MODE_TOUCH, 'h5555555);
		add_row(MODE_EVICT, '0);
		add_row(MODE_EVICT, PAGE_MAX);
		add_row(MODE_INSERT, 'h7654321);
		// drain to empty, then evict once more
		for (int i = 0; i < 7; i++)
			add_row(MODE_EVICT, '0);
		add_fixed(MODE_EVICT, '0, 0, 0, 0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			drive_event(dir_rows[i].m, dir_rows[i].pg, dir_rows[i].fixed, dir_rows[i].res);
			pace();
		end

		// Random part: each segment draws its own evict bias, from filling to draining
		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			if (n % SEGMENT_LEN == 0)
				evict_pct = $urandom_range(5, 55);
			if ($urandom_range(0, 19) == 0)
				pool[$urandom_range(0, POOL_SIZE - 1)] = PB'($urandom);
			r = $urandom_range(0, 99);
			if (r < 3)
				m = MODE_RSVD;
			else if (r < 3 + evict_pct)
				m = MODE_EVICT;
			else if ($urandom_range(0, 9) < 6)
				m = MODE_INSERT;
			else
				m = MODE_TOUCH;
			if ($urandom_range(0, 99) < 85)
				pg = pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				pg = PB'($urandom);
			drive_event(m, pg, 1'b0, none);
			if (n == RANDOM_EVENTS - 1)
				start <= 1'b0;
			else
				pace();
		end

		while (outcome_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d inserts, %0d touches, %0d evicts, %0d unused-mode events",
			n_ins, n_tch, n_evt, n_rsvd);
		$display("Hits %0d, full refusals %0d, victims %0d, empty evicts %0d, peak occupancy %0d",
			n_hit, n_full, n_victim, n_empty, max_occ);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/lru_pr_pkg.sv
hdl/lru_page_replacement_top.sv
sim/lru_page_replacement_top_tb.sv
